>>> design/cdr_pkg.sv
// Shared types and constants for the character display refresh engine.
// Holds the request and result structs, operation and command codes, and defaults.
// No dependencies; the other design files apart from cdr_fifo refer to it by scoped names.
`default_nettype none

package cdr_pkg;

    // Default grid size and queue depths.
    localparam int DEF_ROWS   = 2;
    localparam int DEF_COLS   = 16;
    localparam int CMDQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 4;

    // Cell contents after reset or a clear, and the reset value of the none marker.
    localparam logic [7:0] SPACE_CODE      = 8'h20;
    localparam logic [7:0] NONE_CODE_RESET = 8'hFF;

    // Operation carried by an input request.
    typedef enum logic [1:0] {
        OP_TEXT   = 2'd0,
        OP_GLYPH  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_RENDER = 2'd3
    } op_t;

    // Display command carried by a result.
    typedef enum logic {
        CMD_SET_CURSOR = 1'b0,
        CMD_WRITE      = 1'b1
    } cmd_t;

    // States of the back-end sequencer.
    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_SCAN  = 2'd1,
        BK_WRITE = 2'd2,
        BK_FLUSH = 2'd3
    } back_state_t;

    // Input request as seen on the ports.
    typedef struct packed {
        op_t        op;
        logic [5:0] col;
        logic [2:0] row;
        logic [7:0] code;
    } item_t;

    // Result as seen on the ports.
    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] out_col;
        logic       out_row;
        logic [7:0] out_code;
        logic       last;
    } result_t;

    // Classified request passed from the front end to the back end.
    typedef struct packed {
        op_t        op;
        logic [3:0] col;
        logic       row;
        logic [7:0] code;
    } work_t;

endpackage

`default_nettype wire

>>> design/char_display_diff_refresh.sv
// Character display refresh engine, top level. Uses cdr_pkg, cdr_front, cdr_fifo
// and cdr_back. Keeps a draw buffer and a shadow of the screen, both spaces at reset.
//
// Requests enter through push/full and item: text write, glyph write, clear, render.
// Results leave through empty/pop and result; the oldest waiting result is shown
// while empty is low. cfg_wr_en/cfg_wr_data set the glyph none marker (reset 0xFF).
// Writes and clears produce nothing. A render produces a set-cursor to (0,0), then
// for each changed cell in row-major order an optional set-cursor and a write; the
// final command of a render has last set.
// A request crosses the front end in its accept cycle and waits in a four-entry work
// queue. The back end retires writes and clears at one per cycle while no render is
// running. A render scans the grid at one cell per cycle, pausing on a changed cell
// while the result queue is full, and passes through a separate write state for each
// changed cell that needs a cursor move. The opening set-cursor is held until the scan
// produces the next command, so the first result enters the result queue when the scan
// reaches the first changed cell, or at the end of the scan when nothing changed.
// When the receiver stops popping, the four-entry result queue fills, the scan
// pauses, the work queue fills and full rises. Reset empties both queues, ends any
// render and sets both buffers to spaces.
`default_nettype none

module char_display_diff_refresh #(
    parameter int ROWS = cdr_pkg::DEF_ROWS,
    parameter int COLS = cdr_pkg::DEF_COLS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [7:0]       cfg_wr_data,
    input  wire logic             push,
    input  wire cdr_pkg::item_t   item,
    output logic                  full,
    output logic                  empty,
    input  wire logic             pop,
    output cdr_pkg::result_t      result
);

    logic             cmdq_push;
    logic             cmdq_full;
    logic             cmdq_pop;
    logic             cmdq_empty;
    cdr_pkg::work_t   cmdq_wr;
    cdr_pkg::work_t   cmdq_rd;
    logic             resq_push;
    logic             resq_full;
    cdr_pkg::result_t resq_wr;

    // Front end: configuration and request classification.
    cdr_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .item        (item),
        .full        (full),
        .cmdq_full   (cmdq_full),
        .cmdq_push   (cmdq_push),
        .cmdq_data   (cmdq_wr)
    );

    // Work queue between the two halves.
    cdr_fifo #(
        .T     (cdr_pkg::work_t),
        .DEPTH (cdr_pkg::CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmdq_push),
        .wr_data (cmdq_wr),
        .full    (cmdq_full),
        .pop     (cmdq_pop),
        .rd_data (cmdq_rd),
        .empty   (cmdq_empty)
    );

    // Back end: buffers and render scan.
    cdr_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmdq_empty (cmdq_empty),
        .cmdq_data  (cmdq_rd),
        .cmdq_pop   (cmdq_pop),
        .resq_full  (resq_full),
        .resq_push  (resq_push),
        .resq_data  (resq_wr)
    );

    // Result queue toward the display side.
    cdr_fifo #(
        .T     (cdr_pkg::result_t),
        .DEPTH (cdr_pkg::RESQ_DEPTH)
    ) u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (resq_push),
        .wr_data (resq_wr),
        .full    (resq_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

`default_nettype wire

>>> design/cdr_fifo.sv
// Small synchronous queue built from registers, used between the front and back ends
// and on the result side. Depends only on its type and depth parameters.
`default_nettype none

module cdr_fifo #(
    parameter type T     = logic [7:0],
    parameter int  DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire T     wr_data,
    output logic      full,
    input  wire logic pop,
    output T          rd_data,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Status flags and read data.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage; holds payload only, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> design/cdr_front.sv
// Front end of the refresh engine: holds the none marker register and classifies
// each input request, dropping writes that can have no effect. Uses cdr_pkg.
`default_nettype none

module cdr_front #(
    parameter int ROWS = cdr_pkg::DEF_ROWS,
    parameter int COLS = cdr_pkg::DEF_COLS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wr_en,
    input  wire logic [7:0]     cfg_wr_data,
    input  wire logic           push,
    input  wire cdr_pkg::item_t item,
    output logic                full,
    input  wire logic           cmdq_full,
    output logic                cmdq_push,
    output cdr_pkg::work_t      cmdq_data
);

    logic [7:0] none_code_reg, none_code_next;
    logic       accept;
    logic       in_grid;
    logic       keep;

    // Configuration register.
    assign none_code_next = cfg_wr_en ? cfg_wr_data : none_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            none_code_reg <= cdr_pkg::NONE_CODE_RESET;
        end
        else
        begin
            none_code_reg <= none_code_next;
        end
    end

    // Requests are taken whenever the work queue has room.
    assign full   = cmdq_full;
    assign accept = push && !cmdq_full;

    // Writes outside the grid and transparent glyphs are dropped here.
    assign in_grid = (item.col < 6'(COLS)) && (item.row < 3'(ROWS));

    always_comb
    begin
        keep = 1'b1;
        case (item.op)
            cdr_pkg::OP_TEXT:  keep = in_grid;
            cdr_pkg::OP_GLYPH: keep = in_grid && (item.code != none_code_reg);
            default:           keep = 1'b1;
        endcase
    end

    assign cmdq_push      = accept && keep;
    assign cmdq_data.op   = item.op;
    assign cmdq_data.col  = item.col[3:0];
    assign cmdq_data.row  = item.row[0];
    assign cmdq_data.code = item.code;

endmodule

`default_nettype wire

>>> design/cdr_back.sv
// Back end of the refresh engine: holds the draw buffer and the shadow of the screen,
// carries out writes and clears, and scans the grid on a render. Uses cdr_pkg.
`default_nettype none

module cdr_back #(
    parameter int ROWS = cdr_pkg::DEF_ROWS,
    parameter int COLS = cdr_pkg::DEF_COLS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmdq_empty,
    input  wire cdr_pkg::work_t cmdq_data,
    output logic                cmdq_pop,
    input  wire logic           resq_full,
    output logic                resq_push,
    output cdr_pkg::result_t    resq_data
);

    localparam int CELLS = ROWS * COLS;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CUR_W = $clog2(COLS + 1);

    cdr_pkg::back_state_t state_reg, state_next;

    logic [7:0]        draw_reg  [CELLS];
    logic [7:0]        shown_reg [CELLS];
    logic [COL_W-1:0]  x_reg, x_next;
    logic [ROW_W-1:0]  y_reg, y_next;
    logic [CUR_W-1:0]  cx_reg, cx_next;
    logic [ROW_W-1:0]  cy_reg, cy_next;
    logic              pend_valid_reg, pend_valid_next;
    cdr_pkg::result_t  pend_reg, pend_next;

    logic [CELL_W-1:0] scan_idx;
    logic [CELL_W-1:0] cmd_idx;
    logic [7:0]        draw_cell;
    logic              cell_diff;
    logic              cur_match;
    logic              at_end;
    logic              go;

    logic              draw_we;
    logic              draw_clr;
    logic              shown_we;
    logic              start;
    logic              advance;
    logic              emit_en;
    logic              flush_push;
    cdr_pkg::result_t  emit_res;
    cdr_pkg::result_t  cursor_res;
    cdr_pkg::result_t  write_res;

    // Cell addressing and comparison at the scan position.
    assign scan_idx  = CELL_W'(int'(y_reg) * COLS + int'(x_reg));
    assign cmd_idx   = CELL_W'(int'(cmdq_data.row) * COLS + int'(cmdq_data.col));
    assign draw_cell = draw_reg[scan_idx];
    assign cell_diff = (draw_cell != shown_reg[scan_idx]);
    assign cur_match = (cx_reg == CUR_W'(x_reg)) && (cy_reg == y_reg);
    assign at_end    = (x_reg == COL_W'(COLS - 1)) && (y_reg == ROW_W'(ROWS - 1));
    assign go        = !resq_full;

    // The two kinds of command a scan can produce.
    always_comb
    begin
        cursor_res          = '0;
        cursor_res.cmd      = cdr_pkg::CMD_SET_CURSOR;
        cursor_res.out_col  = 4'(x_reg);
        cursor_res.out_row  = 1'(y_reg);
        write_res           = '0;
        write_res.cmd       = cdr_pkg::CMD_WRITE;
        write_res.out_code  = draw_cell;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdr_pkg::BK_IDLE:
            begin
                if (!cmdq_empty && (cmdq_data.op == cdr_pkg::OP_RENDER))
                begin
                    state_next = cdr_pkg::BK_SCAN;
                end
            end
            cdr_pkg::BK_SCAN:
            begin
                if (!cell_diff || (go && cur_match))
                begin
                    state_next = at_end ? cdr_pkg::BK_FLUSH : cdr_pkg::BK_SCAN;
                end
                else if (go)
                begin
                    state_next = cdr_pkg::BK_WRITE;
                end
            end
            cdr_pkg::BK_WRITE:
            begin
                if (go)
                begin
                    state_next = at_end ? cdr_pkg::BK_FLUSH : cdr_pkg::BK_SCAN;
                end
            end
            cdr_pkg::BK_FLUSH:
            begin
                if (go)
                begin
                    state_next = cdr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cdr_pkg::BK_IDLE;
            end
        endcase
    end

    // Output and datapath controls of the sequencer.
    always_comb
    begin
        cmdq_pop   = 1'b0;
        draw_we    = 1'b0;
        draw_clr   = 1'b0;
        shown_we   = 1'b0;
        start      = 1'b0;
        advance    = 1'b0;
        emit_en    = 1'b0;
        flush_push = 1'b0;
        emit_res   = write_res;
        case (state_reg)
            cdr_pkg::BK_IDLE:
            begin
                if (!cmdq_empty)
                begin
                    cmdq_pop = 1'b1;
                    case (cmdq_data.op)
                        cdr_pkg::OP_TEXT,
                        cdr_pkg::OP_GLYPH:  draw_we  = 1'b1;
                        cdr_pkg::OP_CLEAR:  draw_clr = 1'b1;
                        cdr_pkg::OP_RENDER: start    = 1'b1;
                        default:            draw_we  = 1'b0;
                    endcase
                end
            end
            cdr_pkg::BK_SCAN:
            begin
                if (!cell_diff)
                begin
                    advance = 1'b1;
                end
                else if (go && !cur_match)
                begin
                    emit_en  = 1'b1;
                    emit_res = cursor_res;
                end
                else if (go)
                begin
                    emit_en  = 1'b1;
                    shown_we = 1'b1;
                    advance  = 1'b1;
                end
            end
            cdr_pkg::BK_WRITE:
            begin
                if (go)
                begin
                    emit_en  = 1'b1;
                    shown_we = 1'b1;
                    advance  = 1'b1;
                end
            end
            cdr_pkg::BK_FLUSH:
            begin
                flush_push = go;
            end
            default:
            begin
                cmdq_pop = 1'b0;
            end
        endcase
    end

    // The newest command is held back one step so the final one can be marked last.
    assign resq_push = (emit_en && pend_valid_reg) || flush_push;

    always_comb
    begin
        resq_data      = pend_reg;
        resq_data.last = flush_push;
    end

    // Next values of the scan position, tracked cursor and held command.
    always_comb
    begin
        x_next          = x_reg;
        y_next          = y_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (start)
        begin
            x_next          = '0;
            y_next          = '0;
            cx_next         = '0;
            cy_next         = '0;
            pend_valid_next = 1'b1;
            pend_next       = '0;
            pend_next.cmd   = cdr_pkg::CMD_SET_CURSOR;
        end
        if (advance && !at_end)
        begin
            if (x_reg == COL_W'(COLS - 1))
            begin
                x_next = '0;
                y_next = y_reg + 1'b1;
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
        if (emit_en)
        begin
            pend_next = emit_res;
            if (emit_res.cmd == cdr_pkg::CMD_SET_CURSOR)
            begin
                cx_next = CUR_W'(x_reg);
                cy_next = y_reg;
            end
            else
            begin
                cx_next = CUR_W'(x_reg) + 1'b1;
            end
        end
        if (flush_push)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cdr_pkg::BK_IDLE;
            x_reg          <= '0;
            y_reg          <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            cx_reg         <= cx_next;
            cy_reg         <= cy_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Held command payload.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // Draw buffer: single-cell writes and whole-buffer clear, spaces after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                draw_reg[i] <= cdr_pkg::SPACE_CODE;
            end
        end
        else if (draw_clr)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                draw_reg[i] <= cdr_pkg::SPACE_CODE;
            end
        end
        else if (draw_we)
        begin
            draw_reg[cmd_idx] <= cmdq_data.code;
        end
    end

    // Shadow of the screen, updated as each changed cell is written out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                shown_reg[i] <= cdr_pkg::SPACE_CODE;
            end
        end
        else if (shown_we)
        begin
            shown_reg[scan_idx] <= draw_cell;
        end
    end

    // A render always holds one command until it ends; outside a render nothing is held.
    a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdr_pkg::BK_IDLE) |-> !pend_valid_reg)
        else $error("command held while sequencer idle");

    a_render_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cdr_pkg::BK_IDLE) |-> pend_valid_reg)
        else $error("no command held during a render");

    // Results are only pushed when the result queue has room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        resq_push |-> !resq_full)
        else $error("result pushed into a full queue");

    // After a cursor move the cursor sits on a cell that still differs.
    a_write_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdr_pkg::BK_WRITE) |-> (cell_diff && cur_match))
        else $error("write state entered without a pending changed cell");

endmodule

`default_nettype wire

>>> verif/display_cmd_checker.sv
// Checker for the character display refresh engine: watches the request, result
// and none-marker channels, predicts the display commands and compares them.
// Depends on cdr_pkg for the request and result structs and the code names.
`timescale 1ns / 100ps

module display_cmd_checker #(
    parameter int ROWS = cdr_pkg::DEF_ROWS,
    parameter int COLS = cdr_pkg::DEF_COLS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             push,
    input  logic             full,
    input  cdr_pkg::item_t   item,
    input  logic             pop,
    input  logic             empty,
    input  cdr_pkg::result_t result,
    output int               fail_count,
    output int               pending_cmds,
    output int               requests_seen,
    output int               renders_seen,
    output int               cmds_seen
);

    localparam int CELLS = ROWS * COLS;

    // Predicted contents of the draw buffer and of the screen shadow.
    logic [7:0] draw_cells [CELLS];
    logic [7:0] shown_cells [CELLS];
    logic [7:0] none_marker;

    // Display commands predicted but not yet popped, oldest first.
    cdr_pkg::result_t expected_cmds [$];

    initial
    begin
        fail_count    = 0;
        requests_seen = 0;
        renders_seen  = 0;
        cmds_seen     = 0;
        pending_cmds  = 0;
    end

    function automatic cdr_pkg::result_t make_cmd(cdr_pkg::cmd_t kind, logic [3:0] col,
                                                  logic row, logic [7:0] code);
        cdr_pkg::result_t cmd;
        cmd.cmd      = kind;
        cmd.out_col  = col;
        cmd.out_row  = row;
        cmd.out_code = code;
        cmd.last     = 1'b0;
        return cmd;
    endfunction

    // A render homes the cursor, then walks the cells in row-major order and
    // emits a cursor move (only when needed) and a write for each changed cell.
    // The previous command is held back so the final one can be marked last.
    task automatic predict_refresh();
        cdr_pkg::result_t held;
        int               cur_x;
        int               cur_y;
        int               idx;
        held  = make_cmd(cdr_pkg::CMD_SET_CURSOR, 4'h0, 1'b0, 8'h00);
        cur_x = 0;
        cur_y = 0;
        for (int y = 0; y < ROWS; y++)
        begin
            for (int x = 0; x < COLS; x++)
            begin
                idx = y * COLS + x;
                if (draw_cells[idx] != shown_cells[idx])
                begin
                    if (cur_x != x || cur_y != y)
                    begin
                        expected_cmds.push_back(held);
                        held  = make_cmd(cdr_pkg::CMD_SET_CURSOR, 4'(x), 1'(y), 8'h00);
                        cur_y = y;
                    end
                    expected_cmds.push_back(held);
                    held  = make_cmd(cdr_pkg::CMD_WRITE, 4'h0, 1'b0, draw_cells[idx]);
                    cur_x = x + 1;
                    shown_cells[idx] = draw_cells[idx];
                end
            end
        end
        held.last = 1'b1;
        expected_cmds.push_back(held);
    endtask

    // Apply one accepted request to the predicted buffers.
    task automatic apply_request(input cdr_pkg::item_t req);
        int idx;
        requests_seen++;
        case (req.op)
            cdr_pkg::OP_TEXT, cdr_pkg::OP_GLYPH:
            begin
                // Off-grid writes are dropped; glyphs equal to the marker are transparent.
                if (int'(req.col) < COLS && int'(req.row) < ROWS &&
                    !(req.op == cdr_pkg::OP_GLYPH && req.code == none_marker))
                begin
                    idx = int'(req.row) * COLS + int'(req.col);
                    draw_cells[idx] = req.code;
                end
            end
            cdr_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    draw_cells[i] = cdr_pkg::SPACE_CODE;
            end
            cdr_pkg::OP_RENDER:
            begin
                renders_seen++;
                predict_refresh();
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endfunction

    // Compare one popped display command with the oldest prediction.
    task automatic compare_cmd(input cdr_pkg::result_t got);
        cdr_pkg::result_t want;
        cmds_seen++;
        if (expected_cmds.size() == 0)
        begin
            $error("display command 0x%0h popped with nothing expected", got);
            fail_count++;
        end
        else
        begin
            want = expected_cmds.pop_front();
            check_field("cmd", 8'(want.cmd), 8'(got.cmd));
            check_field("out_col", 8'(want.out_col), 8'(got.out_col));
            check_field("out_row", 8'(want.out_row), 8'(got.out_row));
            check_field("out_code", want.out_code, got.out_code);
            check_field("last", 8'(want.last), 8'(got.last));
        end
    endtask

    // Sample all channels at the clock edge: marker write, then request, then pop.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                draw_cells[i]  = cdr_pkg::SPACE_CODE;
                shown_cells[i] = cdr_pkg::SPACE_CODE;
            end
            none_marker = cdr_pkg::NONE_CODE_RESET;
            expected_cmds.delete();
            pending_cmds <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                none_marker = cfg_wr_data;
            if (push && !full)
                apply_request(item);
            if (pop && !empty)
                compare_cmd(result);
            pending_cmds <= expected_cmds.size();
        end
    end

endmodule

>>> verif/char_display_diff_refresh_tb.sv
// Testbench top for the character display refresh engine: clock, reset, request
// and pop stimulus, watchdog and verdict. Uses cdr_pkg, the block and
// display_cmd_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module char_display_diff_refresh_tb;

    localparam int ROWS          = cdr_pkg::DEF_ROWS;
    localparam int COLS          = cdr_pkg::DEF_COLS;
    localparam int SETTLE_CYCLES = 2 * (2 + 2 * ROWS * COLS);
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [7:0]       cfg_wr_data = 8'h00;
    logic             push        = 1'b0;
    cdr_pkg::item_t   item        = '0;
    logic             full;
    logic             empty;
    logic             pop         = 1'b0;
    cdr_pkg::result_t result;

    int fail_count;
    int pending_cmds;
    int requests_seen;
    int renders_seen;
    int cmds_seen;

    // Stimulus knobs shared between the sender and the receiver.
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    bit         hold_off    = 1'b0;
    logic [7:0] cur_none    = cdr_pkg::NONE_CODE_RESET;
    int         quiet_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    char_display_diff_refresh #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .item        (item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    display_cmd_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_cmd_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .push          (push),
        .full          (full),
        .item          (item),
        .pop           (pop),
        .empty         (empty),
        .result        (result),
        .fail_count    (fail_count),
        .pending_cmds  (pending_cmds),
        .requests_seen (requests_seen),
        .renders_seen  (renders_seen),
        .cmds_seen     (cmds_seen)
    );

    function automatic cdr_pkg::item_t mk(cdr_pkg::op_t op, int col, int row, int code);
        cdr_pkg::item_t req;
        req.op   = op;
        req.col  = 6'(col);
        req.row  = 3'(row);
        req.code = 8'(code);
        return req;
    endfunction

    // Mostly well-formed drawing with renders mixed in; some off-grid noise.
    function automatic cdr_pkg::item_t random_req(int render_pct);
        int             pick;
        int             col;
        int             row;
        int             code;
        cdr_pkg::item_t req;
        pick = $urandom_range(99);
        code = $urandom_range(255);
        if (pick < render_pct)
            req = mk(cdr_pkg::OP_RENDER, $urandom_range(63), $urandom_range(7), code);
        else if (pick < render_pct + 4)
            req = mk(cdr_pkg::OP_CLEAR, $urandom_range(63), $urandom_range(7), code);
        else if (pick < render_pct + 12)
        begin
            col = $urandom_range(63);
            row = $urandom_range(7);
            if (col < COLS && row < ROWS)
                row = $urandom_range(7, ROWS);
            req = mk($urandom_range(1) ? cdr_pkg::OP_GLYPH : cdr_pkg::OP_TEXT,
                     col, row, code);
        end
        else if (pick < render_pct + 40)
        begin
            if ($urandom_range(4) == 0)
                code = int'(cur_none);
            req = mk(cdr_pkg::OP_GLYPH, $urandom_range(COLS - 1),
                     $urandom_range(ROWS - 1), code);
        end
        else
        begin
            if ($urandom_range(9) == 0)
                code = int'(cur_none);
            req = mk(cdr_pkg::OP_TEXT, $urandom_range(COLS - 1),
                     $urandom_range(ROWS - 1), code);
        end
        return req;
    endfunction

    // Offer one request, idling each cycle with the sender's idle chance first,
    // and hold it until it is accepted.
    task automatic send_req(input cdr_pkg::item_t req);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_random(int count, int render_pct);
        for (int i = 0; i < count; i++)
            send_req(random_req(render_pct));
    endtask

    // Stop sending until every predicted command is popped and the block is quiet.
    task automatic drain_commands();
        push <= 1'b0;
        @(posedge clk);
        while (pending_cmds != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_none_code(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_none     = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random pops, with one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: too long without any request or command moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no request or command moved for %0d cycles", QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the marker at its reset value.
        tx_idle_pct = 14;
        rx_idle_pct = 45;
        send_req(mk(cdr_pkg::OP_RENDER, 0, 0, 0));          // nothing changed: home only
        send_req(mk(cdr_pkg::OP_TEXT, 0, 0, 8'h00));
        send_req(mk(cdr_pkg::OP_TEXT, COLS - 1, ROWS - 1, 8'hFF));
        send_req(mk(cdr_pkg::OP_GLYPH, 1, 0, 8'hFF));       // transparent glyph
        send_req(mk(cdr_pkg::OP_GLYPH, 2, 0, 8'h41));
        send_req(mk(cdr_pkg::OP_TEXT, COLS, 0, 8'h42));     // off-grid column
        send_req(mk(cdr_pkg::OP_GLYPH, 63, 7, 8'h43));      // off-grid corner
        send_req(mk(cdr_pkg::OP_TEXT, 0, ROWS, 8'h44));     // off-grid row
        send_req(mk(cdr_pkg::OP_RENDER, 0, 0, 0));
        send_req(mk(cdr_pkg::OP_RENDER, 63, 7, 8'hFF));     // repeat render: no change
        send_req(mk(cdr_pkg::OP_TEXT, 5, 0, cdr_pkg::SPACE_CODE)); // same as shown
        send_req(mk(cdr_pkg::OP_TEXT, 6, 0, 8'h41));
        send_req(mk(cdr_pkg::OP_TEXT, 7, 0, 8'h42));        // adjacent: no cursor move
        send_req(mk(cdr_pkg::OP_TEXT, COLS - 1, 0, 8'h44));
        send_req(mk(cdr_pkg::OP_TEXT, 0, 1, 8'h45));        // wrap needs a cursor move
        send_req(mk(cdr_pkg::OP_RENDER, 0, 0, 0));
        send_req(mk(cdr_pkg::OP_CLEAR, 63, 7, 8'hFF));
        send_req(mk(cdr_pkg::OP_RENDER, 0, 0, 0));          // everything back to spaces
        send_req(mk(cdr_pkg::OP_TEXT, 3, 1, 8'h80));
        send_req(mk(cdr_pkg::OP_RENDER, 0, 0, 0));
        drain_commands();

        // Marker at zero, sender lightly idle and receiver heavily idle.
        write_none_code(8'h00);
        send_random(145, 20);
        drain_commands();

        // Marker at all ones, idling swapped.
        write_none_code(8'hFF);
        tx_idle_pct = 45;
        rx_idle_pct = 14;
        send_random(145, 20);
        drain_commands();

        // Random marker, no idling, then a long receiver hold-off to back up both queues.
        write_none_code(8'($urandom_range(254, 1)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(120, 20);
        hold_off = 1'b1;
        send_random(40, 50);
        drain_commands();

        $display("Covered %0d requests with %0d renders and checked %0d display commands,",
                 requests_seen, renders_seen, cmds_seen);
        $display("across three none-marker settings, idle mixes and a full-queue backup.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
